// ===== sv/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants and width helpers for the segment intersection test block.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int OUT_WIDTH       = 48;
   localparam int TOL_WIDTH       = 16;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
   localparam int FIFO_DEPTH      = 4;

   // Width of the signed direction determinant.
   function automatic int det_w(input int cw);
      return 2 * (cw + 1) + 1;
   endfunction

   // Width of the unsigned numerator magnitude handed to the divider.
   function automatic int nx_w(input int cw, input int f);
      int nw;
      nw = 3 * cw + 3 + f;
      return (nw > OUT_WIDTH) ? nw : OUT_WIDTH + 1;
   endfunction

   // Width of one queue entry between the front and back halves.
   function automatic int qent_w(input int cw, input int f);
      return 8 * cw + 1 + det_w(cw) + 2 * nx_w(cw, f) + 4;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sit_fifo.sv =====
// ----------------------------------------------------------------------------
// sit_fifo
// Small register queue that decouples the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sit_pkg::FIFO_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sit_front.sv =====
// ----------------------------------------------------------------------------
// sit_front
// Four-stage front half: direction determinant, line constants and Cramer
// numerators, then sign, magnitude and overflow screening for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_front #(
   parameter int CW = sit_pkg::COORD_WIDTH_DEF,
   parameter int F  = sit_pkg::FRAC_BITS_DEF,
   parameter int QW = sit_pkg::qent_w(sit_pkg::COORD_WIDTH_DEF, sit_pkg::FRAC_BITS_DEF)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [CW-1:0] a_start_x,
   input  wire logic signed [CW-1:0] a_start_y,
   input  wire logic signed [CW-1:0] a_end_x,
   input  wire logic signed [CW-1:0] a_end_y,
   input  wire logic signed [CW-1:0] b_start_x,
   input  wire logic signed [CW-1:0] b_start_y,
   input  wire logic signed [CW-1:0] b_end_x,
   input  wire logic signed [CW-1:0] b_end_y,
   output logic                      push,
   output logic             [QW-1:0] push_data,
   input  wire logic                 full
);

   localparam int DW   = CW + 1;
   localparam int PPW  = 2 * CW;
   localparam int DDW  = 2 * DW;
   localparam int DETW = sit_pkg::det_w(CW);
   localparam int C1W  = 2 * CW + 1;
   localparam int MW   = C1W + DW;
   localparam int TW   = MW + 1;
   localparam int NXW  = sit_pkg::nx_w(CW, F);
   localparam int QB   = sit_pkg::OUT_WIDTH;

   typedef struct packed {
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_type;

   typedef struct packed {
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic                 par;
      logic [DETW-1:0]      den;
      logic [NXW-1:0]       num_x;
      logic [NXW-1:0]       num_y;
      logic                 neg_x, neg_y, ovf_x, ovf_y;
   } qent_type;

   logic en;
   logic [3:0] v_ff, v_in;
   seg_type seg0, seg1_ff, seg2_ff, seg3_ff, seg4_ff;

   logic signed [DW-1:0]   d1x1_ff, d1y1_ff, d2x1_ff, d2y1_ff;
   logic signed [DW-1:0]   d1x1_in, d1y1_in, d2x1_in, d2y1_in;
   logic signed [PPW-1:0]  pa_ff, pb_ff, pc_ff, pd_ff, pa_in, pb_in, pc_in, pd_in;
   logic signed [DW-1:0]   d1x2_ff, d1y2_ff, d2x2_ff, d2y2_ff;
   logic signed [DDW-1:0]  da_ff, db_ff, da_in, db_in;
   logic signed [C1W-1:0]  c1_ff, c2_ff, c1_in, c2_in;
   logic signed [DETW-1:0] det3_ff, det3_in, det4_ff;
   logic signed [MW-1:0]   m1_ff, m2_ff, m3_ff, m4_ff, m1_in, m2_in, m3_in, m4_in;
   logic signed [TW-1:0]   xt_ff, yt_ff, xt_in, yt_in;

   logic [TW-1:0]   xt_abs, yt_abs;
   logic [DETW-1:0] det_abs;
   qent_type        qent;

   assign en       = !full;
   assign in_ready = en;
   assign push     = v_ff[3] && en;
   assign v_in     = {v_ff[2:0], in_valid};

   assign seg0 = '{a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y};

   // Stage 1: edge directions and the cross terms of the line constants.
   always_comb begin
      d1x1_in = DW'(seg0.ax0) - DW'(seg0.ax1);
      d1y1_in = DW'(seg0.ay0) - DW'(seg0.ay1);
      d2x1_in = DW'(seg0.bx0) - DW'(seg0.bx1);
      d2y1_in = DW'(seg0.by0) - DW'(seg0.by1);
      pa_in   = PPW'(seg0.ax0) * PPW'(seg0.ay1);
      pb_in   = PPW'(seg0.ay0) * PPW'(seg0.ax1);
      pc_in   = PPW'(seg0.bx0) * PPW'(seg0.by1);
      pd_in   = PPW'(seg0.by0) * PPW'(seg0.bx1);
   end

   // Stage 2: determinant products and line constants.
   always_comb begin
      da_in = DDW'(d1x1_ff) * DDW'(d2y1_ff);
      db_in = DDW'(d1y1_ff) * DDW'(d2x1_ff);
      c1_in = C1W'(pa_ff) - C1W'(pb_ff);
      c2_in = C1W'(pc_ff) - C1W'(pd_ff);
   end

   // Stage 3: determinant and numerator products.
   always_comb begin
      det3_in = DETW'(da_ff) - DETW'(db_ff);
      m1_in   = MW'(c1_ff) * MW'(d2x2_ff);
      m2_in   = MW'(d1x2_ff) * MW'(c2_ff);
      m3_in   = MW'(c1_ff) * MW'(d2y2_ff);
      m4_in   = MW'(d1y2_ff) * MW'(c2_ff);
   end

   // Stage 4: Cramer numerators.
   always_comb begin
      xt_in = TW'(m1_ff) - TW'(m2_ff);
      yt_in = TW'(m3_ff) - TW'(m4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg1_ff <= seg0;
         d1x1_ff <= d1x1_in;
         d1y1_ff <= d1y1_in;
         d2x1_ff <= d2x1_in;
         d2y1_ff <= d2y1_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         pc_ff   <= pc_in;
         pd_ff   <= pd_in;
         seg2_ff <= seg1_ff;
         d1x2_ff <= d1x1_ff;
         d1y2_ff <= d1y1_ff;
         d2x2_ff <= d2x1_ff;
         d2y2_ff <= d2y1_ff;
         da_ff   <= da_in;
         db_ff   <= db_in;
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         seg3_ff <= seg2_ff;
         det3_ff <= det3_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         m3_ff   <= m3_in;
         m4_ff   <= m4_in;
         seg4_ff <= seg3_ff;
         det4_ff <= det3_ff;
         xt_ff   <= xt_in;
         yt_ff   <= yt_in;
      end
   end

   // The quotient fits in the output width only when the numerator bits above
   // it are smaller than the divisor; otherwise the divider result saturates.
   always_comb begin
      xt_abs  = xt_ff[TW-1] ? -xt_ff : xt_ff;
      yt_abs  = yt_ff[TW-1] ? -yt_ff : yt_ff;
      det_abs = det4_ff[DETW-1] ? -det4_ff : det4_ff;
      qent.ax0   = seg4_ff.ax0;
      qent.ay0   = seg4_ff.ay0;
      qent.ax1   = seg4_ff.ax1;
      qent.ay1   = seg4_ff.ay1;
      qent.bx0   = seg4_ff.bx0;
      qent.by0   = seg4_ff.by0;
      qent.bx1   = seg4_ff.bx1;
      qent.by1   = seg4_ff.by1;
      qent.par   = (det4_ff == '0);
      qent.den   = det_abs;
      qent.num_x = NXW'({xt_abs, {F{1'b0}}});
      qent.num_y = NXW'({yt_abs, {F{1'b0}}});
      qent.neg_x = xt_ff[TW-1] ^ det4_ff[DETW-1];
      qent.neg_y = yt_ff[TW-1] ^ det4_ff[DETW-1];
      qent.ovf_x = (qent.num_x >> QB) >= NXW'(det_abs);
      qent.ovf_y = (qent.num_y >> QB) >= NXW'(det_abs);
   end

   assign push_data = qent;

endmodule

`default_nettype wire

// ===== sv/sit_div.sv =====
// ----------------------------------------------------------------------------
// sit_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_div #(
   parameter int NUMW = 65,
   parameter int DENW = 35,
   parameter int QB   = sit_pkg::OUT_WIDTH
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [NUMW-1:0] num,
   input  wire logic [DENW-1:0] den,
   output logic      [QB-1:0]   quot
);

   logic [DENW-1:0] rem_ff [QB];
   logic [DENW-1:0] rem_in [QB];
   logic [QB-1:0]   low_ff [QB];
   logic [QB-1:0]   low_in [QB];
   logic [QB-1:0]   q_ff   [QB];
   logic [QB-1:0]   q_in   [QB];
   logic [DENW-1:0] den_ff [QB];
   logic [DENW-1:0] den_in [QB];

   logic [NUMW-1:0] num_hi;
   logic [DENW-1:0] rem_prev [QB];
   logic [QB-1:0]   low_prev [QB];
   logic [QB-1:0]   q_prev   [QB];
   logic [DENW-1:0] den_prev [QB];
   logic [DENW:0]   trial    [QB];
   logic            ge       [QB];

   // The starting remainder is the numerator above the quotient bits; it is
   // below the divisor whenever the quotient does not overflow.
   assign num_hi = num >> QB;

   always_comb begin
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            rem_prev[k] = DENW'(num_hi);
            low_prev[k] = num[QB-1:0];
            q_prev[k]   = '0;
            den_prev[k] = den;
         end else begin
            rem_prev[k] = rem_ff[k-1];
            low_prev[k] = low_ff[k-1];
            q_prev[k]   = q_ff[k-1];
            den_prev[k] = den_ff[k-1];
         end
         trial[k]  = {rem_prev[k], low_prev[k][QB-1]};
         ge[k]     = trial[k] >= {1'b0, den_prev[k]};
         rem_in[k] = ge[k] ? DENW'(trial[k] - {1'b0, den_prev[k]}) : trial[k][DENW-1:0];
         low_in[k] = {low_prev[k][QB-2:0], 1'b0};
         q_in[k]   = {q_prev[k][QB-2:0], ge[k]};
         den_in[k] = den_prev[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QB; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quot = q_ff[QB-1];

endmodule

`default_nettype wire

// ===== sv/sit_back.sv =====
// ----------------------------------------------------------------------------
// sit_back
// Back half: quotient pipeline, saturation, and the two on-segment tests.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_back #(
   parameter int CW = sit_pkg::COORD_WIDTH_DEF,
   parameter int F  = sit_pkg::FRAC_BITS_DEF,
   parameter int QW = sit_pkg::qent_w(sit_pkg::COORD_WIDTH_DEF, sit_pkg::FRAC_BITS_DEF)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [sit_pkg::TOL_WIDTH-1:0]    tol,
   input  wire logic [QW-1:0]                    pop_data,
   input  wire logic                             empty,
   output logic                                  pop,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic                                  hit,
   output logic                                  lines_parallel,
   output logic signed [sit_pkg::OUT_WIDTH-1:0]  cross_x,
   output logic signed [sit_pkg::OUT_WIDTH-1:0]  cross_y
);

   localparam int OUTW = sit_pkg::OUT_WIDTH;
   localparam int QB   = OUTW;
   localparam int DW   = CW + 1;
   localparam int DETW = sit_pkg::det_w(CW);
   localparam int NXW  = sit_pkg::nx_w(CW, F);
   localparam int PW   = ((OUTW > CW + F) ? OUTW : CW + F) + 1;
   localparam int PRW  = PW + DW;
   localparam int XW   = PRW + 1;
   localparam int SQW  = 2 * DW + 1;
   localparam int L2W  = SQW + F;
   localparam int LCW  = (XW > L2W + 1) ? XW : L2W + 1;

   localparam logic signed [OUTW-1:0] SAT_MAX = {1'b0, {(OUTW-1){1'b1}}};
   localparam logic signed [OUTW-1:0] SAT_MIN = {1'b1, {(OUTW-1){1'b0}}};
   localparam logic [QB-1:0] HALF_RANGE = {1'b1, {(QB-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic                 par;
      logic [DETW-1:0]      den;
      logic [NXW-1:0]       num_x;
      logic [NXW-1:0]       num_y;
      logic                 neg_x, neg_y, ovf_x, ovf_y;
   } qent_type;

   typedef struct packed {
      logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic                 par;
      logic                 neg_x, neg_y, ovf_x, ovf_y;
   } side_type;

   // One on-segment test: edge direction and point offset from the start.
   typedef struct packed {
      logic signed [DW-1:0] dx, dy;
      logic signed [PW-1:0] cx, cy;
   } ofs_type;

   typedef struct packed {
      logic signed [PRW-1:0] dxcy, dycx, dxcx, dycy;
      logic [SQW-1:0]        sq;
   } prod_type;

   logic     en;
   qent_type qent;
   logic [QB-1:0] quot_x, quot_y;

   side_type side_ff [QB];
   side_type side_in [QB];
   logic [QB-1:0] dv_ff, dv_in;

   logic     v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vo_ff, vo_in;
   side_type side1_ff;
   logic signed [OUTW-1:0] px1_ff, py1_ff, px1_in, py1_in;
   ofs_type  u1_2_ff, u2_2_ff, u1_2_in, u2_2_in;
   logic     par2_ff, par3_ff;
   logic signed [OUTW-1:0] px2_ff, py2_ff, px3_ff, py3_ff;
   prod_type pr1_ff, pr2_ff, pr1_in, pr2_in;
   logic     hit_ff, hit_in, par_o_ff;
   logic signed [OUTW-1:0] cx_o_ff, cy_o_ff;

   logic     on1, on2;

   assign qent = pop_data;
   assign en   = !vo_ff || out_ready;
   assign pop  = !empty && en;

   sit_div #(.NUMW(NXW), .DENW(DETW), .QB(QB)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (qent.num_x),
      .den   (qent.den),
      .quot  (quot_x)
   );

   sit_div #(.NUMW(NXW), .DENW(DETW), .QB(QB)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (qent.num_y),
      .den   (qent.den),
      .quot  (quot_y)
   );

   // Sideband travels alongside the quotient pipeline.
   always_comb begin
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            side_in[k] = '{qent.ax0, qent.ay0, qent.ax1, qent.ay1,
                           qent.bx0, qent.by0, qent.bx1, qent.by1,
                           qent.par, qent.neg_x, qent.neg_y, qent.ovf_x, qent.ovf_y};
         end else begin
            side_in[k] = side_ff[k-1];
         end
      end
      dv_in = {dv_ff[QB-2:0], pop};
   end

   function automatic logic signed [OUTW-1:0] sat_quot(input logic [QB-1:0] q,
                                                      input logic neg,
                                                      input logic ovf);
      logic signed [OUTW-1:0] r;
      if (ovf) begin
         r = neg ? SAT_MIN : SAT_MAX;
      end else if (!neg) begin
         r = q[QB-1] ? SAT_MAX : q;
      end else begin
         r = (q > HALF_RANGE) ? SAT_MIN : -q;
      end
      return r;
   endfunction

   function automatic ofs_type make_ofs(input logic signed [CW-1:0] sx0,
                                        input logic signed [CW-1:0] sy0,
                                        input logic signed [CW-1:0] sx1,
                                        input logic signed [CW-1:0] sy1,
                                        input logic signed [PW-1:0] qx,
                                        input logic signed [PW-1:0] qy);
      ofs_type o;
      o.dx = DW'(sx1) - DW'(sx0);
      o.dy = DW'(sy1) - DW'(sy0);
      o.cx = qx - PW'($signed({sx0, {F{1'b0}}}));
      o.cy = qy - PW'($signed({sy0, {F{1'b0}}}));
      return o;
   endfunction

   function automatic prod_type make_prod(input ofs_type o);
      prod_type p;
      p.dxcy = PRW'(o.dx) * PRW'(o.cy);
      p.dycx = PRW'(o.dy) * PRW'(o.cx);
      p.dxcx = PRW'(o.dx) * PRW'(o.cx);
      p.dycy = PRW'(o.dy) * PRW'(o.cy);
      p.sq   = SQW'(SQW'(o.dx) * SQW'(o.dx) + SQW'(o.dy) * SQW'(o.dy));
      return p;
   endfunction

   function automatic logic on_test(input prod_type p,
                                    input logic [sit_pkg::TOL_WIDTH-1:0] t);
      logic signed [XW-1:0]  cr, dt;
      logic [XW-1:0]         cr_abs;
      logic signed [LCW-1:0] dt_ext, len_ext;
      cr      = XW'(p.dxcy) - XW'(p.dycx);
      dt      = XW'(p.dxcx) + XW'(p.dycy);
      cr_abs  = cr[XW-1] ? -cr : cr;
      dt_ext  = LCW'(dt);
      len_ext = $signed(LCW'({p.sq, {F{1'b0}}}));
      return (cr_abs <= XW'(t)) && !dt[XW-1] && (dt_ext < len_ext);
   endfunction

   // Saturate the quotients; parallel lines report the origin.
   always_comb begin
      v1_in  = dv_ff[QB-1];
      px1_in = side_ff[QB-1].par ? '0 :
               sat_quot(quot_x, side_ff[QB-1].neg_x, side_ff[QB-1].ovf_x);
      py1_in = side_ff[QB-1].par ? '0 :
               sat_quot(quot_y, side_ff[QB-1].neg_y, side_ff[QB-1].ovf_y);
   end

   // For parallel lines both tests check segment A, against the two ends of B.
   // Otherwise the crossing point is checked against A and against B.
   always_comb begin
      v2_in = v1_ff;
      if (side1_ff.par) begin
         u1_2_in = make_ofs(side1_ff.ax0, side1_ff.ay0, side1_ff.ax1, side1_ff.ay1,
                            PW'($signed({side1_ff.bx0, {F{1'b0}}})),
                            PW'($signed({side1_ff.by0, {F{1'b0}}})));
         u2_2_in = make_ofs(side1_ff.ax0, side1_ff.ay0, side1_ff.ax1, side1_ff.ay1,
                            PW'($signed({side1_ff.bx1, {F{1'b0}}})),
                            PW'($signed({side1_ff.by1, {F{1'b0}}})));
      end else begin
         u1_2_in = make_ofs(side1_ff.ax0, side1_ff.ay0, side1_ff.ax1, side1_ff.ay1,
                            PW'(px1_ff), PW'(py1_ff));
         u2_2_in = make_ofs(side1_ff.bx0, side1_ff.by0, side1_ff.bx1, side1_ff.by1,
                            PW'(px1_ff), PW'(py1_ff));
      end
   end

   always_comb begin
      v3_in  = v2_ff;
      pr1_in = make_prod(u1_2_ff);
      pr2_in = make_prod(u2_2_ff);
   end

   always_comb begin
      vo_in  = en ? v3_ff : vo_ff;
      on1    = on_test(pr1_ff, tol);
      on2    = on_test(pr2_ff, tol);
      hit_in = par3_ff ? (on1 || on2) : (on1 && on2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en) begin
            dv_ff <= dv_in;
            v1_ff <= v1_in;
            v2_ff <= v2_in;
            v3_ff <= v3_in;
         end
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QB; k++) begin
            side_ff[k] <= side_in[k];
         end
         side1_ff <= side_ff[QB-1];
         px1_ff   <= px1_in;
         py1_ff   <= py1_in;
         u1_2_ff  <= u1_2_in;
         u2_2_ff  <= u2_2_in;
         par2_ff  <= side1_ff.par;
         px2_ff   <= px1_ff;
         py2_ff   <= py1_ff;
         pr1_ff   <= pr1_in;
         pr2_ff   <= pr2_in;
         par3_ff  <= par2_ff;
         px3_ff   <= px2_ff;
         py3_ff   <= py2_ff;
         hit_ff   <= hit_in;
         par_o_ff <= par3_ff;
         cx_o_ff  <= px3_ff;
         cy_o_ff  <= py3_ff;
      end
   end

   assign out_valid      = vo_ff;
   assign hit            = hit_ff;
   assign lines_parallel = par_o_ff;
   assign cross_x        = cx_o_ff;
   assign cross_y        = cy_o_ff;

endmodule

`default_nettype wire

// ===== sv/segment_intersection_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Tests whether two integer line segments touch or cross.
//
// A request carries the two endpoints of segment A and of segment B. Each
// response gives hit, lines_parallel and the intersection point in fixed
// point (zero for parallel lines), in request order.
// The front half computes the determinant and Cramer numerators in four
// stages and writes a four-entry queue. The back half divides in a pipeline
// that resolves one quotient bit per cycle (48 stages), then runs the two
// point-on-segment tests in three stages and an output register.
// One request is taken every cycle while the queue is not full.
// When the receiver stalls, the back half holds in place and the queue
// fills; req_ready drops once the queue is full.
// Reset empties the pipeline and the queue and sets the collinear tolerance
// to 1. The tolerance is written through csr_wr_en/csr_wr_data; the user must
// do so only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_test_top #(
   parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = sit_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]       req_a_start_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_a_start_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_a_end_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_a_end_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_b_start_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_b_start_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_b_end_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_b_end_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output logic                                     rsp_lines_parallel,
   output logic signed [sit_pkg::OUT_WIDTH-1:0]     rsp_cross_x,
   output logic signed [sit_pkg::OUT_WIDTH-1:0]     rsp_cross_y,
   input  wire logic                                csr_wr_en,
   input  wire logic [sit_pkg::TOL_WIDTH-1:0]       csr_wr_data
);

   localparam int QW = sit_pkg::qent_w(COORD_WIDTH, FRAC_BITS);

   logic [sit_pkg::TOL_WIDTH-1:0] tol_ff, tol_in;
   logic          push, full, pop, empty;
   logic [QW-1:0] push_data, pop_data;

   assign tol_in = csr_wr_en ? csr_wr_data : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= sit_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   sit_front #(.CW(COORD_WIDTH), .F(FRAC_BITS), .QW(QW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .a_start_x (req_a_start_x),
      .a_start_y (req_a_start_y),
      .a_end_x   (req_a_end_x),
      .a_end_y   (req_a_end_y),
      .b_start_x (req_b_start_x),
      .b_start_y (req_b_start_y),
      .b_end_x   (req_b_end_x),
      .b_end_y   (req_b_end_y),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   sit_fifo #(.WIDTH(QW), .DEPTH(sit_pkg::FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   sit_back #(.CW(COORD_WIDTH), .F(FRAC_BITS), .QW(QW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .tol            (tol_ff),
      .pop_data       (pop_data),
      .empty          (empty),
      .pop            (pop),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .hit            (rsp_hit),
      .lines_parallel (rsp_lines_parallel),
      .cross_x        (rsp_cross_x),
      .cross_y        (rsp_cross_y)
   );

endmodule

`default_nettype wire

// ===== test/tb_segment_intersection_test_top.sv =====
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_top
// Self-checking bench for the segment intersection block. Requests are
// driven with random gaps, responses are taken with random stalls, and
// each response is compared field by field with a prediction made in the
// bench from the same endpoints and the current collinear tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_test_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = sit_pkg::COORD_WIDTH_DEF;
   localparam int FB = sit_pkg::FRAC_BITS_DEF;
   localparam int OW = sit_pkg::OUT_WIDTH;
   localparam int TW = sit_pkg::TOL_WIDTH;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT = 5000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   typedef struct packed {
      logic hit;
      logic par;
      logic signed [OW-1:0] px;
      logic signed [OW-1:0] py;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_type req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit, rsp_lines_parallel;
   logic signed [OW-1:0] rsp_cross_x, rsp_cross_y;
   logic csr_wr_en = 1'b0;
   logic [TW-1:0] csr_wr_data = '0;

   logic [TW-1:0] tolerance;
   verdict_type expected_verdicts[$];
   int mismatches = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   segment_intersection_test_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_lines_parallel(rsp_lines_parallel),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Point (px,py) in fixed point against integer segment s0->s1.
   function automatic bit point_on_segment(longint sx0, longint sy0, longint sx1,
                                           longint sy1, logic signed [127:0] px,
                                           logic signed [127:0] py);
      logic signed [127:0] dx, dy, cx, cy, crs, dt, len2, mag;
      dx = 128'(sx1 - sx0);
      dy = 128'(sy1 - sy0);
      cx = px - (128'(sx0) <<< FB);
      cy = py - (128'(sy0) <<< FB);
      crs = dx * cy - dy * cx;
      dt = dx * cx + dy * cy;
      len2 = (dx * dx + dy * dy) <<< FB;
      mag = crs < 0 ? -crs : crs;
      return mag <= $signed({112'd0, tolerance}) && dt >= 0 && dt < len2;
   endfunction

   // Truncating signed division, saturated to the output width.
   function automatic logic signed [OW-1:0] sat_quotient(logic signed [127:0] num,
                                                         logic signed [127:0] den);
      logic signed [127:0] q, lim;
      q = num / den;
      lim = (128'sd1 <<< (OW - 1));
      if (q > lim - 1) q = lim - 1;
      if (q < -lim) q = -lim;
      return q[OW-1:0];
   endfunction

   function automatic verdict_type predict_intersection(seg_pair_type s);
      longint x1, y1, x2, y2, x3, y3, x4, y4, det, c1, c2;
      logic signed [127:0] xt, yt;
      verdict_type v;
      x1 = longint'(s.ax0); y1 = longint'(s.ay0);
      x2 = longint'(s.ax1); y2 = longint'(s.ay1);
      x3 = longint'(s.bx0); y3 = longint'(s.by0);
      x4 = longint'(s.bx1); y4 = longint'(s.by1);
      det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      v = '0;
      if (det == 0) begin
         v.par = 1'b1;
         v.hit = point_on_segment(x1, y1, x2, y2, 128'(x3) <<< FB, 128'(y3) <<< FB)
              || point_on_segment(x1, y1, x2, y2, 128'(x4) <<< FB, 128'(y4) <<< FB);
      end else begin
         c1 = x1 * y2 - y1 * x2;
         c2 = x3 * y4 - y3 * x4;
         xt = 128'(c1) * 128'(x3 - x4) - 128'(x1 - x2) * 128'(c2);
         yt = 128'(c1) * 128'(y3 - y4) - 128'(y1 - y2) * 128'(c2);
         v.px = sat_quotient(xt <<< FB, 128'(det));
         v.py = sat_quotient(yt <<< FB, 128'(det));
         v.hit = point_on_segment(x1, y1, x2, y2, 128'(v.px), 128'(v.py))
              && point_on_segment(x3, y3, x4, y4, 128'(v.px), 128'(v.py));
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                  input logic [OW-1:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Response side: random stalls, compare against oldest prediction.
   initial begin
      int stall;
      verdict_type want;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected response", '0, '0);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", OW'(rsp_hit), OW'(want.hit));
            if (rsp_lines_parallel !== want.par)
               report_mismatch("lines_parallel", OW'(rsp_lines_parallel), OW'(want.par));
            if (rsp_cross_x !== want.px) report_mismatch("cross_x", rsp_cross_x, want.px);
            if (rsp_cross_y !== want.py) report_mismatch("cross_y", rsp_cross_y, want.py);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // The valid line is dropped only before a gap or when the bench goes idle.
   task automatic send_pair(input seg_pair_type s, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
       req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y} <= s;
      do @(posedge clock); while (!req_ready);
      expected_verdicts.push_back(predict_intersection(s));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [TW-1:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tolerance = value;
   endtask

   function automatic seg_pair_type make_pair(coord_type a, coord_type b, coord_type c,
                                              coord_type d, coord_type e, coord_type f,
                                              coord_type g, coord_type h);
      return {a, b, c, d, e, f, g, h};
   endfunction

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic test_directed();
      coord_type mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));     // plain crossing
      send_pair(make_pair(0, 0, 10, 0, 20, 1, 20, 5));      // no touch
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 20, 0));       // collinear overlap
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0));      // touch at end, excluded
      send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));       // parallel apart
      send_pair(make_pair(3, 3, 3, 3, 3, 3, 3, 3));         // both degenerate
      send_pair(make_pair(3, 3, 3, 3, 0, 0, 5, 6));         // one degenerate
      send_pair(make_pair(0, 0, 3, 1, 0, 1, 1, 0));         // fractional, truncated
      send_pair(make_pair(0, 0, -3, 1, 0, -1, -1, 0));      // negative quotient
      send_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn)); // full-range crossing
      send_pair(make_pair(mx, mx, mn, mn, mx, mn, mn, mx));
      send_pair(make_pair(mn, mn, mx, mn + 1, mx, mx, mn, mx - 1)); // far point
      send_pair(make_pair(mn, 0, mx, 1, mn, 1, mx, 0));
      send_pair(make_pair(0, 0, 1, 0, mx, mn, mn, mx));
      send_pair(make_pair(mx, mx, mx, mx, mn, mn, mn, mn));
      send_pair(make_pair(0, 0, 2, 1, 0, 0, 2, 1));         // identical segments
   endtask

   task automatic test_random(input int count);
      seg_pair_type s;
      int span, kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         span = (kind < 3) ? 0 : (kind < 7 ? 20 : 1000);
         s = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                       rand_coord(span), rand_coord(span), rand_coord(span),
                       rand_coord(span), rand_coord(span));
         if (kind == 7) begin
            // B along the line of A, often overlapping.
            s.bx0 = coord_type'(s.ax0 + (s.ax1 - s.ax0) * $signed($urandom_range(0, 2) - 1));
            s.by0 = coord_type'(s.ay0 + (s.ay1 - s.ay0) * $signed($urandom_range(0, 2) - 1));
            s.bx1 = s.ax1; s.by1 = s.ay1;
         end
         send_pair(s, (i % 200) < 30);
      end
   endtask

   initial begin
      tolerance = sit_pkg::TOL_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      set_tolerance('0);
      test_directed();
      test_random(400);
      set_tolerance({TW{1'b1}});
      test_directed();
      test_random(400);
      set_tolerance(16'h5a5a);
      test_random(300);
      set_tolerance(16'd1);
      test_random(300);
      wait_idle();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

`default_nettype wire
